>>> rtl/vnu_pkg.sv
`default_nettype none
package vnu_pkg;

	// component and length formats
	localparam int COMP_W = 24;
	localparam int LEN_W = COMP_W - 1;
	localparam int FRAC_W = 20;
	localparam int NLANE = 3;

	// normalized sum of squares and its root
	localparam int NORM_W = 64;
	localparam int ROOT_W = NORM_W / 2;
	localparam int SHIFT_W = $clog2(ROOT_W);

	// scaling: product, rounded numerator, quotient
	localparam int PROD_W = ROOT_W + LEN_W;
	localparam int NUM_W = PROD_W + 1;
	localparam int QUO_W = LEN_W + 1;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	// per-item data that rides along with the arithmetic
	typedef struct packed {
		logic [NLANE-1:0][COMP_W-1:0] mag;
		logic [NLANE-1:0]             neg;
		logic [LEN_W-1:0]             len;
		logic                         zero;
	} vec_side_t;

	typedef struct packed {
		vec_side_t          side;
		logic [SHIFT_W-1:0] shift;
		logic [NORM_W-1:0]  nsum;
	} norm_item_t;

	typedef struct packed {
		vec_side_t          side;
		logic [SHIFT_W-1:0] shift;
	} root_side_t;

	typedef struct packed {
		root_side_t        side;
		logic [ROOT_W-1:0] root;
	} root_item_t;

	typedef struct packed {
		logic [NLANE-1:0][COMP_W-1:0] comp;
		logic                         zero;
		logic                         sat;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/vector3_normalize_unit.sv
`default_nettype none
// channel   | direction | handshake            | beat
// ----------+-----------+----------------------+----------------------------------
// input     | in        | push / full          | x_in, y_in, z_in, length_in
// result    | out       | pop / empty          | x_out, y_out, z_out, zero_vector,
//           |           |                      | saturated
// config    | in        | psel/penable/pwrite  | paddr 0: length_source,
//           |           |                      | paddr 4: target_length
//
// One beat per cycle sustained while full is low and results are popped;
// each beat passes the front (square, sum, 5-step normalize), the queue, the
// root pipeline and the scaler (multiply, round, 24-step divide, output).
// Reset clears all valid bits and the queue; registers return to length
// source 0 and target 1.0. A held result stalls the back part; the front
// keeps running until the 4-entry queue fills, then full rises.
module vector3_normalize_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              push,
	output logic                              full,
	input  logic signed [vnu_pkg::COMP_W-1:0] x_in,
	input  logic signed [vnu_pkg::COMP_W-1:0] y_in,
	input  logic signed [vnu_pkg::COMP_W-1:0] z_in,
	input  logic        [vnu_pkg::LEN_W-1:0]  length_in,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [vnu_pkg::COMP_W-1:0] x_out,
	output logic signed [vnu_pkg::COMP_W-1:0] y_out,
	output logic signed [vnu_pkg::COMP_W-1:0] z_out,
	output logic                              zero_vector,
	output logic                              saturated
);
	import vnu_pkg::*;

	typedef enum logic {
		REG_LEN_SRC = 1'b0,
		REG_TARGET  = 1'b1
	} reg_idx_t;

	logic             len_src_q;
	logic [LEN_W-1:0] target_len_q;
	reg_idx_t         reg_idx;
	logic             en_f, en_b;
	logic             f_v, fifo_full, fifo_empty, fifo_push, fifo_pop;
	norm_item_t       f_item, q_item;
	logic             r_v;
	root_item_t       r_item;
	logic             res_v;
	result_t          res;

	// config registers
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_src_q    <= 1'b0;
			target_len_q <= LEN_W'(1) << FRAC_W;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_LEN_SRC: len_src_q    <= pwdata[0];
				REG_TARGET:  target_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (reg_idx)
			REG_LEN_SRC: prdata = {31'b0, len_src_q};
			REG_TARGET:  prdata = 32'(target_len_q);
			default:     prdata = '0;
		endcase
	end

	// front stalls only when its last stage cannot enter the queue
	assign en_f      = !(f_v && fifo_full);
	assign full      = !en_f;
	assign fifo_push = f_v && !fifo_full;
	// back stalls only while a result waits
	assign en_b      = !res_v || pop;
	assign fifo_pop  = en_b && !fifo_empty;

	vnu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (push),
		.x         (x_in),
		.y         (y_in),
		.z         (z_in),
		.len       (len_src_q ? length_in : target_len_q),
		.out_valid (f_v),
		.out_item  (f_item)
	);

	vnu_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fifo_push),
		.wr_item (f_item),
		.pop     (fifo_pop),
		.rd_item (q_item),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	vnu_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (!fifo_empty),
		.in_item   (q_item),
		.out_valid (r_v),
		.out_item  (r_item)
	);

	vnu_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (r_v),
		.in_item   (r_item),
		.out_valid (res_v),
		.out_res   (res)
	);

	assign empty       = !res_v;
	assign x_out       = res.comp[0];
	assign y_out       = res.comp[1];
	assign z_out       = res.comp[2];
	assign zero_vector = res.zero;
	assign saturated   = res.sat;

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && zero_vector |-> x_out == '0 && y_out == '0 && z_out == '0 && !saturated)
		else $error("zero vector result not cleared");

endmodule
`default_nettype wire

>>> rtl/vnu_front.sv
`default_nettype none
module vnu_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [vnu_pkg::COMP_W-1:0]   x,
	input  logic signed [vnu_pkg::COMP_W-1:0]   y,
	input  logic signed [vnu_pkg::COMP_W-1:0]   z,
	input  logic        [vnu_pkg::LEN_W-1:0]    len,
	output logic                                out_valid,
	output vnu_pkg::norm_item_t                 out_item
);
	import vnu_pkg::*;

	logic [NLANE-1:0][COMP_W-1:0]   comp_c;
	logic [NLANE-1:0][COMP_W-1:0]   mag_c;
	vec_side_t                      side_s1, side_s2, side_s3;
	logic                           v_s1, v_s2, v_s3;
	logic [NLANE-1:0][2*COMP_W-1:0] sq_s2;
	logic [NORM_W-1:0]              sum_s3;
	norm_item_t                     nrm_s [0:SHIFT_W];
	logic                           nrm_v_s [0:SHIFT_W];

	// magnitudes and signs
	assign comp_c = {z, y, x};
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			mag_c[l] = comp_c[l][COMP_W-1] ? COMP_W'(~comp_c[l] + 1'b1) : comp_c[l];
		end
	end

	// valid chain of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1 capture, s2 squares, s3 sum and zero test
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.mag  <= mag_c;
			side_s1.neg  <= {z[COMP_W-1], y[COMP_W-1], x[COMP_W-1]};
			side_s1.len  <= len;
			side_s1.zero <= 1'b0;
			side_s2      <= side_s1;
			for (int l = 0; l < NLANE; l++) begin
				sq_s2[l] <= (2*COMP_W)'(side_s1.mag[l]) * (2*COMP_W)'(side_s1.mag[l]);
			end
			side_s3      <= '{mag: side_s2.mag, neg: side_s2.neg, len: side_s2.len,
			                  zero: (sq_s2 == '0)};
			sum_s3       <= NORM_W'(sq_s2[0]) + NORM_W'(sq_s2[1]) + NORM_W'(sq_s2[2]);
		end
	end

	assign nrm_v_s[0]     = v_s3;
	assign nrm_s[0].side  = side_s3;
	assign nrm_s[0].shift = '0;
	assign nrm_s[0].nsum  = sum_s3;

	// leading-zero search by bit pairs, one shift size per stage
	for (genvar j = 0; j < SHIFT_W; j++) begin : g_norm
		localparam int K = SHIFT_W - 1 - j;
		localparam int SH = 2 << K;
		logic hit_c;
		assign hit_c = (nrm_s[j].nsum[NORM_W-1 -: SH] == '0);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) nrm_v_s[j+1] <= 1'b0;
			else if (en) nrm_v_s[j+1] <= nrm_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				nrm_s[j+1].side  <= nrm_s[j].side;
				nrm_s[j+1].shift <= nrm_s[j].shift | (SHIFT_W'(hit_c) << K);
				nrm_s[j+1].nsum  <= hit_c ? (nrm_s[j].nsum << SH) : nrm_s[j].nsum;
			end
		end
	end

	assign out_valid = nrm_v_s[SHIFT_W];
	assign out_item  = nrm_s[SHIFT_W];

endmodule
`default_nettype wire

>>> rtl/vnu_fifo.sv
`default_nettype none
module vnu_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vnu_pkg::norm_item_t wr_item,
	input  logic                pop,
	output vnu_pkg::norm_item_t rd_item,
	output logic                full,
	output logic                empty
);
	import vnu_pkg::*;

	norm_item_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");

endmodule
`default_nettype wire

>>> rtl/vnu_sqrt.sv
`default_nettype none
module vnu_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  vnu_pkg::norm_item_t in_item,
	output logic                out_valid,
	output vnu_pkg::root_item_t out_item
);
	import vnu_pkg::*;

	logic              v_s    [0:ROOT_W];
	root_side_t        side_s [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic [ROOT_W:0]   rem_s  [0:ROOT_W-1];
	logic [NORM_W-1:0] rad_s  [0:ROOT_W-1];

	assign v_s[0]          = in_valid;
	assign side_s[0].side  = in_item.side;
	assign side_s[0].shift = in_item.shift;
	assign root_s[0]       = '0;
	assign rem_s[0]        = '0;
	assign rad_s[0]        = in_item.nsum;

	// one root bit per stage, restoring method
	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		logic [ROOT_W+2:0] t_c, trial_c, diff_c;
		logic              ge_c;
		always_comb begin
			t_c     = {rem_s[j], rad_s[j][NORM_W-1 -: 2]};
			trial_c = {1'b0, root_s[j], 2'b01};
			diff_c  = t_c - trial_c;
			ge_c    = (t_c >= trial_c);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j+1] <= 1'b0;
			else if (en) v_s[j+1] <= v_s[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j+1] <= {root_s[j][ROOT_W-2:0], ge_c};
				side_s[j+1] <= side_s[j];
			end
		end
		if (j < ROOT_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= ge_c ? diff_c[ROOT_W:0] : t_c[ROOT_W:0];
					rad_s[j+1] <= rad_s[j] << 2;
				end
			end
		end
	end

	assign out_valid     = v_s[ROOT_W];
	assign out_item.side = side_s[ROOT_W];
	assign out_item.root = root_s[ROOT_W];

endmodule
`default_nettype wire

>>> rtl/vnu_scale.sv
`default_nettype none
module vnu_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  vnu_pkg::root_item_t in_item,
	output logic                out_valid,
	output vnu_pkg::result_t    out_res
);
	import vnu_pkg::*;

	localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] NEG_MAG = {1'b1, {(QUO_W-1){1'b0}}};

	logic [NLANE-1:0][ROOT_W-1:0] a_c;
	logic [NLANE-1:0][PROD_W-1:0] prod_s1;
	logic [NLANE-1:0][NUM_W-1:0]  num_s2;
	vec_side_t                    side_s1, side_s2;
	logic [ROOT_W-1:0]            root_s1, root_s2;
	logic                         v_s1, v_s2;

	logic                         dv_v_s    [0:QUO_W];
	vec_side_t                    dv_side_s [0:QUO_W];
	logic [NLANE-1:0][QUO_W-1:0]  dv_lo_s   [0:QUO_W];
	logic [NLANE-1:0][ROOT_W-1:0] dv_rem_s  [0:QUO_W-1];
	logic [ROOT_W-1:0]            dv_div_s  [0:QUO_W-1];

	result_t                      res_c, res_q;
	logic                         res_v_q;

	// scaled-up magnitudes
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			a_c[l] = ROOT_W'(in_item.side.side.mag[l]) << in_item.side.shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// s1 multiply by target length, s2 add half the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NLANE; l++) begin
				prod_s1[l] <= PROD_W'(a_c[l]) * PROD_W'(in_item.side.side.len);
				num_s2[l]  <= NUM_W'(prod_s1[l]) + NUM_W'(root_s1 >> 1);
			end
			side_s1 <= in_item.side.side;
			root_s1 <= in_item.root;
			side_s2 <= side_s1;
			root_s2 <= root_s1;
		end
	end

	assign dv_v_s[0]    = v_s2;
	assign dv_side_s[0] = side_s2;
	assign dv_div_s[0]  = root_s2;
	for (genvar l = 0; l < NLANE; l++) begin : g_init
		assign dv_rem_s[0][l] = num_s2[l][NUM_W-1 -: ROOT_W];
		assign dv_lo_s[0][l]  = num_s2[l][QUO_W-1:0];
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		logic [NLANE-1:0][ROOT_W:0]   t_c;
		logic [NLANE-1:0][ROOT_W:0]   diff_c;
		logic [NLANE-1:0]             ge_c;
		always_comb begin
			for (int l = 0; l < NLANE; l++) begin
				t_c[l]    = {dv_rem_s[j][l], dv_lo_s[j][l][QUO_W-1]};
				diff_c[l] = t_c[l] - {1'b0, dv_div_s[j]};
				ge_c[l]   = (t_c[l] >= {1'b0, dv_div_s[j]});
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (en) dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[j+1] <= dv_side_s[j];
				for (int l = 0; l < NLANE; l++) begin
					dv_lo_s[j+1][l] <= {dv_lo_s[j][l][QUO_W-2:0], ge_c[l]};
				end
			end
		end
		if (j < QUO_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					dv_div_s[j+1] <= dv_div_s[j];
					for (int l = 0; l < NLANE; l++) begin
						dv_rem_s[j+1][l] <= ge_c[l] ? diff_c[l][ROOT_W-1:0]
						                            : t_c[l][ROOT_W-1:0];
					end
				end
			end
		end
	end

	// sign, clamp and zero-vector override
	always_comb begin
		res_c.zero = dv_side_s[QUO_W].zero;
		res_c.sat  = 1'b0;
		for (int l = 0; l < NLANE; l++) begin
			if (dv_side_s[QUO_W].neg[l]) begin
				if (dv_lo_s[QUO_W][l] > NEG_MAG) begin
					res_c.comp[l] = NEG_MAG;
					res_c.sat     = 1'b1;
				end else begin
					res_c.comp[l] = COMP_W'(~dv_lo_s[QUO_W][l] + 1'b1);
				end
			end else begin
				if (dv_lo_s[QUO_W][l] > POS_MAX) begin
					res_c.comp[l] = POS_MAX;
					res_c.sat     = 1'b1;
				end else begin
					res_c.comp[l] = dv_lo_s[QUO_W][l];
				end
			end
		end
		if (dv_side_s[QUO_W].zero) begin
			res_c.comp = '0;
			res_c.sat  = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (en) res_v_q <= dv_v_s[QUO_W];
	end
	always_ff @(posedge clk) begin
		if (en) res_q <= res_c;
	end

	assign out_valid = res_v_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire
